// File: hw/rtl/wavx_pkg.sv
// Shared types, constants and helpers for the WAV header and data extractor.
`timescale 1ns / 1ps

package wavx_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int HDR_LAST_POS    = 35;
  localparam int CHUNK_LAST_POS  = 7;

  // "data" as it sits little-endian in the tag shift register
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam logic [5:0] POS_CH_LO   = 6'd22;
  localparam logic [5:0] POS_CH_HI   = 6'd23;
  localparam logic [5:0] POS_RATE_LO = 6'd24;
  localparam logic [5:0] POS_RATE_HI = 6'd27;
  localparam logic [5:0] POS_BITS_LO = 6'd34;
  localparam logic [5:0] POS_BITS_HI = 6'd35;

  typedef enum logic [1:0] {
    KIND_FMT    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERR    = 2'd2,
    KIND_NODATA = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [1:0]  channel_count;
    logic [31:0] data_length;
  } res_t;

  // Expected bytes of "RIFF" at 0-3 and "WAVEfmt " at 8-15
  function automatic logic [7:0] wavx_magic(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h52;
      4'd1:    val = 8'h49;
      4'd2:    val = 8'h46;
      4'd3:    val = 8'h46;
      4'd8:    val = 8'h57;
      4'd9:    val = 8'h41;
      4'd10:   val = 8'h56;
      4'd11:   val = 8'h45;
      4'd12:   val = 8'h66;
      4'd13:   val = 8'h6d;
      4'd14:   val = 8'h74;
      4'd15:   val = 8'h20;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/wavx_ifs.sv
// Stream interfaces for the WAV extractor input bytes and result requests.
`timescale 1ns / 1ps

interface wavx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface wavx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last_data;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [1:0]  channel_count;
  logic [31:0] data_length;

  modport source (output valid, output kind, output data_byte, output last_data,
                  output sample_rate, output sample_bits, output channel_count,
                  output data_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input last_data,
                  input sample_rate, input sample_bits, input channel_count,
                  input data_length, output ready);
endinterface

// File: hw/rtl/wav_header_and_data_extractor_core.sv
// Top level of the WAV header and data extractor.
`timescale 1ns / 1ps

// Takes one WAV buffer byte per cycle on in_if while in_ready is high
// (end_of_buffer on the final byte), checks the 36-byte RIFF/fmt header, walks
// chunks to "data", then gives one format request (kind 0) followed by the data
// bytes (kind 1, last one marked); kind 2 is a header error and kind 3 means no
// data chunk was found. A result is registered in the result queue and then in
// the output register before it appears on out_if. in_ready falls only when the
// QUEUE_DEPTH-entry result queue between the parser and the output register is
// full, i.e. while out_if is stalled.
module wav_header_and_data_extractor_core import wavx_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wavx_in_if.sink     in_if,
  wavx_out_if.source  out_if
);

  logic res_valid;
  res_t res;
  logic q_not_full;
  logic q_not_empty;
  logic q_pop;
  res_t q_data;

  wavx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_ready   (q_not_full),
    .res_valid (res_valid),
    .res       (res)
  );

  wavx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  wavx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// File: hw/rtl/wavx_front.sv
// Byte parser: walks the RIFF header and chunk list, raises result requests.
`timescale 1ns / 1ps

module wavx_front import wavx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wavx_in_if.sink     in_if,
  input  logic        q_ready,
  output logic        res_valid,
  output res_t        res
);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_BADHDR = 6'b000010,
    PH_CHUNK  = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_WAIT   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] tag_r, tag_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] chan_r, chan_nxt;

  logic        accept;
  logic        last;
  logic [7:0]  b;
  logic        magic_pos;
  logic        bad_now;
  logic        bad_final;
  logic [31:0] chunk_len;
  logic [1:0]  rate_sel;
  logic        emit;
  kind_t       emit_kind;
  logic        emit_last;
  logic [31:0] emit_len;

  assign in_if.ready = q_ready;
  assign accept      = in_if.valid && q_ready;
  assign last        = in_if.end_of_buffer;
  assign b           = in_if.in_byte;

  assign magic_pos = (pos_r < 6'd16) && ((pos_r < 6'd4) || (pos_r >= 6'd8));
  assign bad_now   = (phase_r == PH_BADHDR) ||
                     (magic_pos && (b != wavx_magic(pos_r[3:0])));
  assign bad_final = bad_now || ((chan_r != 16'd1) && (chan_r != 16'd2));
  assign tag_nxt   = {b, tag_r[63:8]};
  assign chunk_len = tag_nxt[63:32];
  assign rate_sel  = 2'(pos_r - POS_RATE_LO);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    chan_nxt  = chan_r;
    emit      = 1'b0;
    emit_kind = KIND_ERR;
    emit_last = 1'b0;
    emit_len  = chunk_len;

    case (phase_r)
      PH_HEADER, PH_BADHDR: begin
        // captured fields never overlap the magic positions
        if (phase_r == PH_HEADER) begin
          if (pos_r == POS_CH_LO)      chan_nxt[7:0]  = b;
          if (pos_r == POS_CH_HI)      chan_nxt[15:8] = b;
          if (pos_r == POS_BITS_LO)    bits_nxt[7:0]  = b;
          if (pos_r == POS_BITS_HI)    bits_nxt[15:8] = b;
          if (pos_r >= POS_RATE_LO && pos_r <= POS_RATE_HI) begin
            case (rate_sel)
              2'd0:    rate_nxt[7:0]   = b;
              2'd1:    rate_nxt[15:8]  = b;
              2'd2:    rate_nxt[23:16] = b;
              default: rate_nxt[31:24] = b;
            endcase
          end
        end
        if (pos_r >= 6'(HDR_LAST_POS)) begin
          pos_nxt = '0;
          if (bad_final) begin
            emit      = 1'b1;
            emit_kind = KIND_ERR;
            phase_nxt = PH_WAIT;
          end else if (last) begin
            emit      = 1'b1;
            emit_kind = KIND_NODATA;
          end else begin
            phase_nxt = PH_CHUNK;
          end
        end else if (last) begin
          emit      = 1'b1;
          emit_kind = KIND_ERR;
        end else begin
          pos_nxt   = pos_r + 6'd1;
          phase_nxt = bad_now ? PH_BADHDR : PH_HEADER;
        end
      end
      PH_CHUNK: begin
        if (pos_r >= 6'(CHUNK_LAST_POS)) begin
          pos_nxt   = '0;
          count_nxt = chunk_len;
          if (tag_nxt[31:0] == DATA_TAG) begin
            emit      = 1'b1;
            emit_kind = KIND_FMT;
            emit_len  = last ? '0 : chunk_len;
            phase_nxt = (chunk_len == '0) ? PH_WAIT : PH_DATA;
          end else if (last) begin
            emit      = 1'b1;
            emit_kind = KIND_NODATA;
          end else begin
            phase_nxt = (chunk_len == '0) ? PH_CHUNK : PH_SKIP;
          end
        end else if (last) begin
          emit      = 1'b1;
          emit_kind = KIND_NODATA;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      PH_SKIP: begin
        if (last) begin
          emit      = 1'b1;
          emit_kind = KIND_NODATA;
        end else begin
          count_nxt = count_r - 32'd1;
          if (count_r <= 32'd1) begin
            phase_nxt = PH_CHUNK;
            pos_nxt   = '0;
          end
        end
      end
      PH_DATA: begin
        emit      = 1'b1;
        emit_kind = KIND_DATA;
        emit_last = last || (count_r <= 32'd1);
        count_nxt = count_r - 32'd1;
        if (count_r <= 32'd1) phase_nxt = PH_WAIT;
      end
      default: begin
      end
    endcase

    // end of buffer always returns to the start of a new header
    if (last) begin
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
    end
  end

  assign res_valid         = accept && emit;
  assign res.kind          = emit_kind;
  assign res.data_byte     = b;
  assign res.last_data     = emit_last;
  assign res.sample_rate   = rate_r;
  assign res.sample_bits   = bits_r;
  assign res.channel_count = chan_r[1:0];
  assign res.data_length   = emit_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= count_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      chan_r  <= chan_nxt;
      if (phase_r == PH_CHUNK) tag_r <= tag_nxt;
    end
  end

endmodule

// File: hw/rtl/wavx_queue.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module wavx_queue import wavx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output res_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)
        count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push)
        count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: hw/rtl/wavx_back.sv
// Output stage: shapes each queued request by kind and holds it for the sink.
`timescale 1ns / 1ps

module wavx_back import wavx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  res_t        q_data,
  output logic        q_pop,
  wavx_out_if.source  out_if
);

  logic out_valid_r;
  res_t out_r, out_nxt;
  logic load;

  // fields outside a kind's meaning are driven as zero
  always_comb begin
    out_nxt      = '0;
    out_nxt.kind = q_data.kind;
    case (q_data.kind)
      KIND_FMT: begin
        out_nxt.sample_rate   = q_data.sample_rate;
        out_nxt.sample_bits   = q_data.sample_bits;
        out_nxt.channel_count = q_data.channel_count;
        out_nxt.data_length   = q_data.data_length;
      end
      KIND_DATA: begin
        out_nxt.data_byte = q_data.data_byte;
        out_nxt.last_data = q_data.last_data;
      end
      default: begin
      end
    endcase
  end

  assign load  = !out_valid_r || out_if.ready;
  assign q_pop = load && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_r <= out_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_r.kind;
  assign out_if.data_byte     = out_r.data_byte;
  assign out_if.last_data     = out_r.last_data;
  assign out_if.sample_rate   = out_r.sample_rate;
  assign out_if.sample_bits   = out_r.sample_bits;
  assign out_if.channel_count = out_r.channel_count;
  assign out_if.data_length   = out_r.data_length;

endmodule
